// ===== design/ctc_pkg.sv =====
// Package for the C token classifier: token codes, keyword tables, queue word type.
`timescale 1ns / 1ps
`default_nettype none

package ctc_pkg;

   // Sizes
   localparam int NUM_KW                = 10;
   localparam int KW_POS                = 8;
   localparam int QUEUE_DEPTH           = 4;
   localparam int DEFAULT_MAX_TOKEN_LEN = 127;

   // Token class codes
   localparam logic [2:0] CLASS_KEYWORD  = 3'd0;
   localparam logic [2:0] CLASS_IDENT    = 3'd1;
   localparam logic [2:0] CLASS_CONST    = 3'd2;
   localparam logic [2:0] CLASS_OPERATOR = 3'd3;
   localparam logic [2:0] CLASS_SYMBOL   = 3'd4;

   // Pending run kind; the unused code reads as no run
   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_IDENT = 2'd1,
      MODE_CONST = 2'd2
   } run_mode_type;

   // Keyword lengths, in keyword number order
   localparam logic [2:0] KW_LEN [NUM_KW] = '{
      3'd3, 3'd5, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd4, 3'd4
   };

   // Keyword text, padded with zeros to eight positions
   localparam logic [7:0] KW_TEXT [NUM_KW][KW_POS] = '{
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
      '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
      '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
      '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"m", "a", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00}
   };

   // One queue word: an optional finished run and an optional operator/symbol
   typedef struct packed {
      logic       run_valid;
      logic [2:0] run_class;
      logic [6:0] run_length;
      logic       run_saturated;
      logic [3:0] run_keyword;
      logic       sym_valid;
      logic [2:0] sym_class;
      logic [7:0] sym_char;
   } work_type;

   // Character classes
   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return c == "+" || c == "-" || c == "*" || c == "/" ||
             c == "=" || c == "<" || c == ">" || c == "%";
   endfunction

   function automatic logic is_symbol(input logic [7:0] c);
      return c == "(" || c == ")" || c == "{" || c == "}" ||
             c == "[" || c == "]" || c == ";" || c == ",";
   endfunction

endpackage

`default_nettype wire

// ===== design/ctc_front.sv =====
// Front end: run tracking, keyword mask narrowing and token classification.
`timescale 1ns / 1ps
`default_nettype none

module ctc_front
   import ctc_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = DEFAULT_MAX_TOKEN_LEN
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_character,
   input  wire logic       req_end_of_text,
   input  wire logic       q_full,
   output logic            push,
   output work_type        work
);

   localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN_LEN);

   run_mode_type        mode_ff, mode_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                ovf_ff, ovf_in;
   logic [NUM_KW-1:0]   cand_ff, cand_in;

   logic                accept;
   logic                letter, digit, oper, symb;
   logic                extend, start;
   logic [LEN_W-1:0]    base_len, add_len;
   logic                base_ovf, add_ovf;
   logic [NUM_KW-1:0]   base_cand, add_cand;
   logic                kw_hit;
   logic [3:0]          kw_idx;
   logic [LEN_W+6:0]    len_ext;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   assign letter = is_letter(req_character);
   assign digit  = is_digit(req_character);
   assign oper   = is_operator(req_character);
   assign symb   = is_symbol(req_character);

   // a character extends the run, or ends it and maybe opens a new one
   assign extend = !req_end_of_text &&
                   ((mode_ff == MODE_IDENT && (letter || digit)) ||
                    (mode_ff == MODE_CONST && digit));
   assign start  = !req_end_of_text && !extend && (letter || digit);

   // character appended to the current run or to a fresh one
   assign base_len  = extend ? len_ff : '0;
   assign base_ovf  = extend ? ovf_ff : 1'b0;
   assign base_cand = extend ? cand_ff : '1;
   assign add_len   = (base_len >= MAX_LEN) ? base_len : base_len + LEN_W'(1);
   assign add_ovf   = base_ovf || (base_len >= MAX_LEN);

   always_comb begin
      for (int i = 0; i < NUM_KW; i++) begin
         add_cand[i] = base_cand[i] && (base_len < LEN_W'(KW_LEN[i])) &&
                       (KW_TEXT[i][base_len[2:0]] == req_character);
      end
   end

   // next run state
   always_comb begin
      mode_in = mode_ff;
      len_in  = len_ff;
      ovf_in  = ovf_ff;
      cand_in = cand_ff;
      if (accept) begin
         if (extend || start) begin
            if (extend) begin
               mode_in = mode_ff;
            end else if (letter) begin
               mode_in = MODE_IDENT;
            end else begin
               mode_in = MODE_CONST;
            end
            len_in  = add_len;
            ovf_in  = add_ovf;
            cand_in = add_cand;
         end else begin
            mode_in = MODE_NONE;
            len_in  = '0;
            ovf_in  = 1'b0;
            cand_in = '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
         cand_ff <= '1;
      end else begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         ovf_ff  <= ovf_in;
         cand_ff <= cand_in;
      end
   end

   // first surviving keyword of matching length
   always_comb begin
      kw_hit = 1'b0;
      kw_idx = '0;
      for (int i = 0; i < NUM_KW; i++) begin
         if (!kw_hit && cand_ff[i] && len_ff == LEN_W'(KW_LEN[i])) begin
            kw_hit = 1'b1;
            kw_idx = 4'(i);
         end
      end
   end

   assign len_ext = {7'b0, len_ff};

   // queue word for this character
   always_comb begin
      work = '0;
      work.run_valid     = !extend && (mode_ff == MODE_IDENT || mode_ff == MODE_CONST);
      work.run_length    = len_ext[6:0];
      work.run_saturated = ovf_ff;
      if (mode_ff == MODE_IDENT) begin
         if (kw_hit && !ovf_ff) begin
            work.run_class   = CLASS_KEYWORD;
            work.run_keyword = kw_idx;
         end else begin
            work.run_class = CLASS_IDENT;
         end
      end else begin
         work.run_class = CLASS_CONST;
      end
      work.sym_valid = !req_end_of_text && (oper || symb);
      work.sym_class = oper ? CLASS_OPERATOR : CLASS_SYMBOL;
      work.sym_char  = req_character;
   end

   assign push = accept && (work.run_valid || work.sym_valid);

endmodule

`default_nettype wire

// ===== design/ctc_queue.sv =====
// Short register queue of classified words between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module ctc_queue
   import ctc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_word,
   input  wire logic     pop,
   output work_type      head_word,
   output logic          empty,
   output logic          full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type         entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_word = entries_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

// ===== design/ctc_back.sv =====
// Back end: splits queue words into result words and drives the output register.
`timescale 1ns / 1ps
`default_nettype none

module ctc_back
   import ctc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire work_type   head_word,
   input  wire logic       empty,
   output logic            pop,
   output logic            pend_valid,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_token_class,
   output logic [6:0]      rsp_token_length,
   output logic            rsp_length_saturated,
   output logic [3:0]      rsp_keyword_number,
   output logic [7:0]      rsp_symbol_char,
   output logic            rsp_last
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] cls_ff, cls_in;
   logic [6:0] len_ff, len_in;
   logic       sat_ff, sat_in;
   logic [3:0] kw_ff, kw_in;
   logic [7:0] chr_ff, chr_in;
   logic       last_ff, last_in;
   logic       pend_valid_ff, pend_valid_in;
   logic [2:0] pend_cls_ff, pend_cls_in;
   logic [7:0] pend_chr_ff, pend_chr_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = out_free && !pend_valid_ff && !empty;

   // load the output register from the held symbol or the queue head
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      cls_in        = cls_ff;
      len_in        = len_ff;
      sat_in        = sat_ff;
      kw_in         = kw_ff;
      chr_in        = chr_ff;
      last_in       = last_ff;
      pend_valid_in = pend_valid_ff;
      pend_cls_in   = pend_cls_ff;
      pend_chr_in   = pend_chr_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            cls_in        = pend_cls_ff;
            len_in        = 7'd1;
            sat_in        = 1'b0;
            kw_in         = '0;
            chr_in        = pend_chr_ff;
            last_in       = 1'b1;
            pend_valid_in = 1'b0;
         end else if (!empty) begin
            rsp_valid_in = 1'b1;
            if (head_word.run_valid) begin
               cls_in        = head_word.run_class;
               len_in        = head_word.run_length;
               sat_in        = head_word.run_saturated;
               kw_in         = head_word.run_keyword;
               chr_in        = '0;
               last_in       = !head_word.sym_valid;
               pend_valid_in = head_word.sym_valid;
               pend_cls_in   = head_word.sym_class;
               pend_chr_in   = head_word.sym_char;
            end else begin
               cls_in  = head_word.sym_class;
               len_in  = 7'd1;
               sat_in  = 1'b0;
               kw_in   = '0;
               chr_in  = head_word.sym_char;
               last_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff      <= cls_in;
      len_ff      <= len_in;
      sat_ff      <= sat_in;
      kw_ff       <= kw_in;
      chr_ff      <= chr_in;
      last_ff     <= last_in;
      pend_cls_ff <= pend_cls_in;
      pend_chr_ff <= pend_chr_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_token_class      = cls_ff;
   assign rsp_token_length     = len_ff;
   assign rsp_length_saturated = sat_ff;
   assign rsp_keyword_number   = kw_ff;
   assign rsp_symbol_char      = chr_ff;
   assign rsp_last             = last_ff;
   assign pend_valid           = pend_valid_ff;

endmodule

`default_nettype wire

// ===== design/c_token_classifier_unit.sv =====
// Top level of the C token classifier: front end, word queue and back end.
// Usage:
//   The req channel takes one character word per cycle while req_ready is high (req_character, or
//   req_end_of_text to flush the pending run). The rsp channel returns token
//   words: class, length, saturation flag, keyword number, symbol character
//   and rsp_last on the final token caused by one character.
//   Throughput: one character per cycle while the queue is not full. A
//   character that both ends a run and is an operator or symbol yields two
//   tokens, which leave one after the other through the single output register.
//   A token is written into the queue when the character that completes it
//   is accepted, and is then loaded from the queue head into the output
//   register, which drives rsp, once that register is free.
//   A four-word queue decouples the sides; req_ready drops only while it is
//   full, so a stalled receiver backs up into the queue before the sender.
//   Reset clears the pending run, the keyword mask, the queue and rsp_valid.
`timescale 1ns / 1ps
`default_nettype none

module c_token_classifier_unit
   import ctc_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = DEFAULT_MAX_TOKEN_LEN
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_character,
   input  wire logic       req_end_of_text,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_token_class,
   output logic [6:0]      rsp_token_length,
   output logic            rsp_length_saturated,
   output logic [3:0]      rsp_keyword_number,
   output logic [7:0]      rsp_symbol_char,
   output logic            rsp_last
);

   work_type push_word;
   work_type head_word;
   logic     push, pop, empty, full, pend_valid;

   ctc_front #(
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_character   (req_character),
      .req_end_of_text (req_end_of_text),
      .q_full          (full),
      .push            (push),
      .work            (push_word)
   );

   ctc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head_word (head_word),
      .empty     (empty),
      .full      (full)
   );

   ctc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_word            (head_word),
      .empty                (empty),
      .pop                  (pop),
      .pend_valid           (pend_valid),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_token_class      (rsp_token_class),
      .rsp_token_length     (rsp_token_length),
      .rsp_length_saturated (rsp_length_saturated),
      .rsp_keyword_number   (rsp_keyword_number),
      .rsp_symbol_char      (rsp_symbol_char),
      .rsp_last             (rsp_last)
   );

   // a held symbol always sits behind a run token in the output register
   a_pend_behind_run: assert property (@(posedge clock) disable iff (reset)
      pend_valid |-> (rsp_valid && !rsp_last))
      else $error("held symbol without a run token in front");

   // operators and symbols are always the final token of their character
   a_symbol_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_token_class == CLASS_OPERATOR ||
                     rsp_token_class == CLASS_SYMBOL)) |-> rsp_last)
      else $error("operator or symbol token not marked last");

   // keywords are never saturated runs
   a_keyword_short: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_class == CLASS_KEYWORD) |-> !rsp_length_saturated)
      else $error("saturated run reported as keyword");

   // the queue is never written while full
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

endmodule

`default_nettype wire

// ===== test/c_token_classifier_unit_tb.sv =====
// Testbench for c_token_classifier_unit: directed table, then random text against a predictor.
`timescale 1ns / 1ps

module c_token_classifier_unit_tb;
   import ctc_pkg::*;

   localparam int MAX_LEN     = DEFAULT_MAX_TOKEN_LEN;
   localparam int RAND_WORDS  = 170;
   localparam int GAP_CAP     = 20;

   typedef struct packed {
      logic [2:0] cls;
      logic [6:0] len;
      logic       sat;
      logic [3:0] kw;
      logic [7:0] sym;
      logic       last;
   } tok_word_type;

   typedef enum logic [2:0] {CK_SKIP, CK_LETTER, CK_DIGIT, CK_OPER, CK_SYMB} char_kind_type;

   // Directed row: character repeated reps times; typed tokens apply to the last repeat
   typedef struct {
      logic [7:0]   ch;
      logic         eot;
      int           reps;
      int           n_typed;
      tok_word_type t0;
      tok_word_type t1;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_character = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_token_class;
   logic [6:0] rsp_token_length;
   logic       rsp_length_saturated;
   logic [3:0] rsp_keyword_number;
   logic [7:0] rsp_symbol_char;
   logic       rsp_last;

   // Predictor state
   run_mode_type      run_kind = MODE_NONE;
   int                run_count = 0;
   logic              run_over = 1'b0;
   logic [NUM_KW-1:0] kw_live = '1;

   tok_word_type tokens_due[$];
   tok_word_type step_tokens[$];
   dir_row_type  dir_rows[$];
   logic [8:0]   text_words[$];
   int           errors = 0;
   int           sender_idle_pct = 0;
   int           rsp_stall_pct = 0;

   logic [7:0] oper_chars [8] = '{"+", "-", "*", "/", "=", "<", ">", "%"};
   logic [7:0] symb_chars [8] = '{"(", ")", "{", "}", "[", "]", ";", ","};
   logic [7:0] blank_chars [3] = '{8'h20, 8'h09, 8'h0A};

   c_token_classifier_unit #(.MAX_TOKEN_LEN(MAX_LEN)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_character(req_character), .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_token_class(rsp_token_class), .rsp_token_length(rsp_token_length),
      .rsp_length_saturated(rsp_length_saturated), .rsp_keyword_number(rsp_keyword_number),
      .rsp_symbol_char(rsp_symbol_char), .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   function automatic tok_word_type tok(input logic [2:0] cls, input logic [6:0] len,
                                        input logic sat, input logic [3:0] kw,
                                        input logic [7:0] sym, input logic last);
      tok_word_type t;
      t.cls = cls; t.len = len; t.sat = sat; t.kw = kw; t.sym = sym; t.last = last;
      return t;
   endfunction

   function automatic char_kind_type char_kind(input logic [7:0] c);
      char_kind_type k;
      k = CK_SKIP;
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_") k = CK_LETTER;
      else if (c >= "0" && c <= "9") k = CK_DIGIT;
      else begin
         case (c)
            "+", "-", "*", "/", "=", "<", ">", "%": k = CK_OPER;
            "(", ")", "{", "}", "[", "]", ";", ",": k = CK_SYMB;
            default: k = CK_SKIP;
         endcase
      end
      return k;
   endfunction

   // Narrow the keyword mask at the current position, then count the character
   task automatic extend_run(input logic [7:0] c);
      int i;
      for (i = 0; i < NUM_KW; i++) begin
         if (run_count >= KW_LEN[i]) kw_live[i] = 1'b0;
         else if (KW_TEXT[i][run_count] != c) kw_live[i] = 1'b0;
      end
      if (run_count >= MAX_LEN) run_over = 1'b1;
      else run_count++;
   endtask

   // Report any pending run and clear it
   task automatic close_run();
      logic [2:0] cls;
      logic [3:0] kw;
      logic       found;
      int         i;
      if (run_kind == MODE_IDENT || run_kind == MODE_CONST) begin
         cls = (run_kind == MODE_IDENT) ? CLASS_IDENT : CLASS_CONST;
         kw = 4'd0;
         found = 1'b0;
         if (run_kind == MODE_IDENT && !run_over) begin
            for (i = 0; i < NUM_KW; i++) begin
               if (!found && kw_live[i] && KW_LEN[i] == run_count) begin
                  found = 1'b1;
                  cls = CLASS_KEYWORD;
                  kw = 4'(i);
               end
            end
         end
         step_tokens.push_back(tok(cls, 7'(run_count), run_over, kw, 8'h00, 1'b0));
      end
      run_kind = MODE_NONE;
      run_count = 0;
      run_over = 1'b0;
      kw_live = '1;
   endtask

   // Tokens caused by one accepted word, left in step_tokens
   task automatic lex_step(input logic [7:0] c, input logic eot);
      char_kind_type k;
      tok_word_type  t;
      k = char_kind(c);
      step_tokens.delete();
      if (eot) close_run();
      else if (run_kind == MODE_IDENT && (k == CK_LETTER || k == CK_DIGIT)) extend_run(c);
      else if (run_kind == MODE_CONST && k == CK_DIGIT) extend_run(c);
      else begin
         close_run();
         case (k)
            CK_LETTER: begin
               run_kind = MODE_IDENT;
               extend_run(c);
            end
            CK_DIGIT: begin
               run_kind = MODE_CONST;
               extend_run(c);
            end
            CK_OPER: step_tokens.push_back(tok(CLASS_OPERATOR, 7'd1, 1'b0, 4'd0, c, 1'b0));
            CK_SYMB: step_tokens.push_back(tok(CLASS_SYMBOL, 7'd1, 1'b0, 4'd0, c, 1'b0));
            default: ;
         endcase
      end
      if (step_tokens.size() > 0) begin
         t = step_tokens[step_tokens.size() - 1];
         t.last = 1'b1;
         step_tokens[step_tokens.size() - 1] = t;
      end
   endtask

   task automatic row(input logic [7:0] ch, input logic eot, input int reps, input int n,
                      input tok_word_type t0, input tok_word_type t1);
      dir_row_type r;
      r.ch = ch; r.eot = eot; r.reps = reps; r.n_typed = n; r.t0 = t0; r.t1 = t1;
      dir_rows.push_back(r);
   endtask

   // Present one word and hold it until accepted
   task automatic send_word(input logic [7:0] ch, input logic eot);
      req_valid <= 1'b1;
      req_character <= ch;
      req_end_of_text <= eot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Sender gap after an accepted word, drawn per cycle
   task automatic sender_gap();
      int gap;
      gap = 0;
      while (gap < GAP_CAP && $urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'(8'h41 + r);
      else if (r < 52) return 8'(8'h61 + r - 26);
      return "_";
   endfunction

   function automatic logic [7:0] rand_name_char();
      if ($urandom_range(0, 4) == 0) return 8'(8'h30 + $urandom_range(0, 9));
      return rand_letter();
   endfunction

   // One random piece of source text, mostly well formed
   task automatic add_piece();
      int pick, n, i, kwn;
      logic sep;
      pick = $urandom_range(0, 99);
      sep = 1'b0;
      if (pick < 22) begin
         // keyword, now and then cut short or extended
         kwn = $urandom_range(0, NUM_KW - 1);
         n = KW_LEN[kwn];
         if ($urandom_range(0, 5) == 0) n = $urandom_range(1, KW_LEN[kwn]);
         for (i = 0; i < n; i++) text_words.push_back({1'b0, KW_TEXT[kwn][i]});
         if ($urandom_range(0, 7) == 0) text_words.push_back({1'b0, rand_name_char()});
         sep = 1'b1;
      end else if (pick < 42) begin
         n = ($urandom_range(0, 40) == 0) ? $urandom_range(120, 135) : $urandom_range(1, 8);
         text_words.push_back({1'b0, rand_letter()});
         for (i = 1; i < n; i++) text_words.push_back({1'b0, rand_name_char()});
         sep = 1'b1;
      end else if (pick < 56) begin
         n = ($urandom_range(0, 30) == 0) ? $urandom_range(124, 132) : $urandom_range(1, 6);
         for (i = 0; i < n; i++) text_words.push_back({1'b0, 8'(8'h30 + $urandom_range(0, 9))});
         sep = 1'b1;
      end else if (pick < 67) begin
         text_words.push_back({1'b0, oper_chars[$urandom_range(0, 7)]});
      end else if (pick < 78) begin
         text_words.push_back({1'b0, symb_chars[$urandom_range(0, 7)]});
      end else if (pick < 86) begin
         text_words.push_back({1'b0, blank_chars[$urandom_range(0, 2)]});
      end else if (pick < 94) begin
         text_words.push_back({1'b0, 8'($urandom_range(0, 255))});
      end else begin
         text_words.push_back({1'b1, 8'($urandom_range(0, 255))});
      end
      if (sep && $urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 2))
            0: text_words.push_back({1'b0, blank_chars[$urandom_range(0, 2)]});
            1: text_words.push_back({1'b0, oper_chars[$urandom_range(0, 7)]});
            default: text_words.push_back({1'b0, symb_chars[$urandom_range(0, 7)]});
         endcase
      end
   endtask

   // Receiver: check each accepted token against the oldest expectation
   always @(posedge clock) begin
      tok_word_type got, want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = tok(rsp_token_class, rsp_token_length, rsp_length_saturated,
                      rsp_keyword_number, rsp_symbol_char, rsp_last);
            if (tokens_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected token cls=%0d len=%0d sat=%0d kw=%0d sym=%h last=%0d",
                        $time, got.cls, got.len, got.sat, got.kw, got.sym, got.last);
            end else begin
               want = tokens_due.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: expected cls=%0d len=%0d sat=%0d kw=%0d sym=%h last=%0d",
                           $time, want.cls, want.len, want.sat, want.kw, want.sym, want.last);
                  $display("%0t: actual   cls=%0d len=%0d sat=%0d kw=%0d sym=%h last=%0d",
                           $time, got.cls, got.len, got.sat, got.kw, got.sym, got.last);
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Stimulus
   initial begin
      tok_word_type nil;
      dir_row_type  r;
      int           i, j, phase;
      nil = '0;

      row(8'h00, 1'b1, 1, 0, nil, nil);       // end of text with nothing pending
      row("i", 1'b0, 1, -1, nil, nil);
      row("n", 1'b0, 1, -1, nil, nil);
      row("t", 1'b0, 1, -1, nil, nil);
      row(" ", 1'b0, 1, 1, tok(CLASS_KEYWORD, 7'd3, 1'b0, 4'd0, 8'h00, 1'b1), nil);
      row("+", 1'b0, 1, 1, tok(CLASS_OPERATOR, 7'd1, 1'b0, 4'd0, "+", 1'b1), nil);
      row("m", 1'b0, 1, -1, nil, nil);
      row("a", 1'b0, 1, -1, nil, nil);
      row("i", 1'b0, 1, -1, nil, nil);
      row("n", 1'b0, 1, -1, nil, nil);
      // keyword closed by a symbol: two tokens
      row("(", 1'b0, 1, 2, tok(CLASS_KEYWORD, 7'd4, 1'b0, 4'd9, 8'h00, 1'b0),
          tok(CLASS_SYMBOL, 7'd1, 1'b0, 4'd0, "(", 1'b1));
      row("9", 1'b0, 2, -1, nil, nil);
      row("x", 1'b0, 1, -1, nil, nil);        // letter after digits
      row(8'hFF, 1'b1, 1, 1, tok(CLASS_IDENT, 7'd1, 1'b0, 4'd0, 8'h00, 1'b1), nil);
      row(8'h00, 1'b0, 1, -1, nil, nil);
      row(8'hFF, 1'b0, 1, -1, nil, nil);
      row("_", 1'b0, 1, -1, nil, nil);
      row("Z", 1'b0, 1, -1, nil, nil);
      row("0", 1'b0, 1, -1, nil, nil);
      row("%", 1'b0, 1, 2, tok(CLASS_IDENT, 7'd3, 1'b0, 4'd0, 8'h00, 1'b0),
          tok(CLASS_OPERATOR, 7'd1, 1'b0, 4'd0, "%", 1'b1));
      row("}", 1'b0, 1, 1, tok(CLASS_SYMBOL, 7'd1, 1'b0, 4'd0, "}", 1'b1), nil);
      // overlong identifier saturates; exactly full constant does not
      row("k", 1'b0, MAX_LEN + 1, -1, nil, nil);
      row(";", 1'b0, 1, 2, tok(CLASS_IDENT, 7'(MAX_LEN), 1'b1, 4'd0, 8'h00, 1'b0),
          tok(CLASS_SYMBOL, 7'd1, 1'b0, 4'd0, ";", 1'b1));
      row("7", 1'b0, MAX_LEN, -1, nil, nil);
      row(8'h00, 1'b1, 1, 1, tok(CLASS_CONST, 7'(MAX_LEN), 1'b0, 4'd0, 8'h00, 1'b1), nil);

      while (text_words.size() < RAND_WORDS) add_piece();
      text_words.push_back({1'b1, 8'h00});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, no idling
      for (i = 0; i < dir_rows.size(); i++) begin
         r = dir_rows[i];
         for (j = 0; j < r.reps; j++) begin
            send_word(r.ch, r.eot);
            lex_step(r.ch, r.eot);
            if (r.n_typed >= 0 && j == r.reps - 1) begin
               if (r.n_typed > 0) tokens_due.push_back(r.t0);
               if (r.n_typed > 1) tokens_due.push_back(r.t1);
            end else begin
               foreach (step_tokens[k]) tokens_due.push_back(step_tokens[k]);
            end
         end
      end

      // Random text over four idling phases
      for (i = 0; i < text_words.size(); i++) begin
         phase = i * 4 / text_words.size();
         case (phase)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 62; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 62; end
            default: begin sender_idle_pct = 31; rsp_stall_pct = 31; end
         endcase
         send_word(text_words[i][7:0], text_words[i][8]);
         lex_step(text_words[i][7:0], text_words[i][8]);
         foreach (step_tokens[k]) tokens_due.push_back(step_tokens[k]);
         sender_gap();
      end
      req_valid <= 1'b0;

      while (tokens_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("c_token_classifier_unit verification clean");
      end else begin
         $display("c_token_classifier_unit verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("c_token_classifier_unit verification failed");
      $finish;
   end

endmodule
